@@ rtl/lht_pkg.sv @@
// shared types, codes and defaults for the lru handle table
`timescale 1ns / 1ps
`default_nettype none

package lht_pkg;

   localparam int WAYS_DEFAULT = 256;
   localparam int KEY_W        = 32;
   localparam int STAMP_W      = 64;
   localparam int STATUS_W     = 3;
   localparam int SLOT_W       = 8;
   localparam int COUNT_W      = 9;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT        = 3'd0,
      ST_FILLED     = 3'd1,
      ST_EVICT_FILL = 3'd2,
      ST_OPEN_FAIL  = 3'd3,
      ST_CLEARED    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_RESP
   } state_type;

   // one table entry as held in the ram word
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

@@ rtl/lht_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface lht_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] key;
   logic        open_ok;

   modport source (output valid, output cmd, output key, output open_ok, input ready);
   modport sink   (input valid, input cmd, input key, input open_ok, output ready);
endinterface

interface lht_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] slot;
   logic       evicted;
   logic [8:0] used_count;

   modport source (output valid, output status, output slot, output evicted,
                   output used_count, input ready);
   modport sink   (input valid, input status, input slot, input evicted,
                   input used_count, output ready);
endinterface

`default_nettype wire

@@ rtl/lht_ram.sv @@
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/lru_handle_table_top.sv @@
// lru handle table: fully associative keyed table with timestamp replacement
// operation: a clear goes from idle straight to the response; an acquire reads the claimed
//   slots one per cycle through the entry ram and its compare unit (none on an empty table),
//   stops at a hit, then decides; one transaction at a time, new requests only when idle
// reset: synchronous, clears the slot count, the use clock and all control state;
//   entries above the slot count are never read, so the ram needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module lru_handle_table_top
   import lht_pkg::*;
#(
   parameter int WAYS = WAYS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lht_req_if.sink    req_ch,
   lht_rsp_if.source  rsp_ch
);

   localparam int IW = $clog2(WAYS);
   localparam int CW = $clog2(WAYS + 1);

   // sequencer
   state_type state_ff, state_in;

   // latched request
   logic [KEY_W-1:0] key_ff, key_in;
   logic             ok_ff, ok_in;

   // scan bookkeeping
   logic [CW-1:0]      issue_ff, issue_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic               hit_ff, hit_in;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in;
   logic               empty_found_ff, empty_found_in;
   logic [IW-1:0]      empty_idx_ff, empty_idx_in;
   logic [IW-1:0]      min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;

   // architectural state
   logic [CW-1:0]      slots_used_ff, slots_used_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;

   // pending result and output register
   status_type         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic               res_evicted_ff, res_evicted_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic               out_evicted_ff, out_evicted_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   // ram port
   logic            ram_wr_en;
   logic [IW-1:0]   ram_wr_addr;
   entry_type       ram_wr_entry;
   logic            ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type       rd_entry;

   // shared compare unit outputs
   logic tag_match;
   logic stamp_lower;
   logic last_slot;

   // miss decision
   logic [IW-1:0] pick;
   logic          evict;
   logic          room_left;
   logic          accept_req;
   logic          out_free;

   assign accept_req = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign rd_entry   = entry_type'(ram_rd_data);

   // one entry per cycle through the compare unit
   assign tag_match   = rd_entry.valid && (rd_entry.tag == key_ff);
   assign stamp_lower = (rd_idx_ff == '0) || (rd_entry.stamp < min_stamp_ff);
   assign last_slot   = (CW'(rd_idx_ff) == (slots_used_ff - CW'(1)));
   assign room_left   = (slots_used_ff < CW'(WAYS));

   // replacement choice: first empty claimed slot, next unclaimed, else oldest
   always_comb begin
      pick  = min_idx_ff;
      evict = 1'b0;
      if (empty_found_ff) begin
         pick = empty_idx_ff;
      end else if (room_left) begin
         pick = IW'(slots_used_ff);
      end else begin
         evict = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept_req) begin
               if (req_ch.cmd) begin
                  state_in = S_RESP;
               end else if (slots_used_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_vld_ff && (tag_match || last_slot)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: state_in = S_RESP;
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      req_ch.ready   = (state_ff == S_IDLE);
      key_in         = key_ff;
      ok_in          = ok_ff;
      issue_in       = issue_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = issue_ff[IW-1:0];
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      min_idx_in     = min_idx_ff;
      min_stamp_in   = min_stamp_ff;
      slots_used_in  = slots_used_ff;
      clock_in       = clock_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_evicted_in = res_evicted_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      out_status_in  = out_status_ff;
      out_slot_in    = out_slot_ff;
      out_evicted_in = out_evicted_ff;
      out_count_in   = out_count_ff;
      ram_rd_en      = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pick;
      ram_wr_entry   = '{valid: 1'b1, tag: key_ff, stamp: clock_ff + STAMP_W'(1)};

      case (state_ff)
         S_IDLE: begin
            if (accept_req) begin
               key_in         = req_ch.key;
               ok_in          = req_ch.open_ok;
               issue_in       = '0;
               hit_in         = 1'b0;
               empty_found_in = 1'b0;
               if (req_ch.cmd) begin
                  // clear: the slot count alone marks every entry as gone
                  slots_used_in  = '0;
                  res_status_in  = ST_CLEARED;
                  res_slot_in    = '0;
                  res_evicted_in = 1'b0;
                  res_count_in   = '0;
               end
            end
         end
         S_SCAN: begin
            // issue the next read while the previous entry is compared
            if (issue_ff < slots_used_ff) begin
               ram_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (tag_match) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end else begin
                  if (!rd_entry.valid && !empty_found_ff) begin
                     empty_found_in = 1'b1;
                     empty_idx_in   = rd_idx_ff;
                  end
                  if (stamp_lower) begin
                     min_idx_in   = rd_idx_ff;
                     min_stamp_in = rd_entry.stamp;
                  end
               end
            end
         end
         S_DECIDE: begin
            res_count_in = COUNT_W'(slots_used_ff);
            if (hit_ff) begin
               // hit: refresh the stamp only
               ram_wr_en      = 1'b1;
               ram_wr_addr    = hit_idx_ff;
               clock_in       = clock_ff + STAMP_W'(1);
               res_status_in  = ST_HIT;
               res_slot_in    = SLOT_W'(hit_idx_ff);
               res_evicted_in = 1'b0;
            end else if (ok_ff) begin
               ram_wr_en      = 1'b1;
               clock_in       = clock_ff + STAMP_W'(1);
               res_status_in  = evict ? ST_EVICT_FILL : ST_FILLED;
               res_slot_in    = SLOT_W'(pick);
               res_evicted_in = evict;
               if (CW'(pick) == slots_used_ff) begin
                  slots_used_in = slots_used_ff + CW'(1);
                  res_count_in  = COUNT_W'(slots_used_ff + CW'(1));
               end
            end else begin
               // failed open: an evicted entry is still dropped
               ram_wr_en          = evict;
               ram_wr_entry.valid = 1'b0;
               res_status_in      = ST_OPEN_FAIL;
               res_slot_in        = SLOT_W'(pick);
               res_evicted_in     = evict;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               out_status_in  = res_status_ff;
               out_slot_in    = res_slot_ff;
               out_evicted_in = res_evicted_ff;
               out_count_in   = res_count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slots_used_ff <= '0;
         clock_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         slots_used_ff <= slots_used_in;
         clock_ff      <= clock_in;
      end
   end

   // payload and scan registers, no reset needed
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      ok_ff          <= ok_in;
      issue_ff       <= issue_in;
      rd_idx_ff      <= rd_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      min_idx_ff     <= min_idx_in;
      min_stamp_ff   <= min_stamp_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_evicted_ff <= res_evicted_in;
      res_count_ff   <= res_count_in;
      out_status_ff  <= out_status_in;
      out_slot_ff    <= out_slot_in;
      out_evicted_ff <= out_evicted_in;
      out_count_ff   <= out_count_in;
   end

   // entry store: valid, tag and stamp in one word
   lht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WAYS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = out_status_ff;
   assign rsp_ch.slot       = out_slot_ff;
   assign rsp_ch.evicted    = out_evicted_ff;
   assign rsp_ch.used_count = out_count_ff;

endmodule

`default_nettype wire
